// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tsd_pkg.sv -----
`timescale 1ns / 1ps

package tsd_pkg;

   localparam int CoordWidth = 12;
   localparam int CountWidth = 8;

   localparam logic [CountWidth-1:0] MAX_TOUCHES     = 8'd2;
   localparam logic [CoordWidth-1:0] THRESHOLD_RESET = 12'd30;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_START = 2'd1;
   localparam logic [1:0] EV_END   = 2'd2;

   localparam logic [2:0] DIR_POINT = 3'd0;
   localparam logic [2:0] DIR_RIGHT = 3'd1;
   localparam logic [2:0] DIR_LEFT  = 3'd2;
   localparam logic [2:0] DIR_UP    = 3'd3;
   localparam logic [2:0] DIR_DOWN  = 3'd4;

   typedef logic [CoordWidth-1:0] coord_type;

   typedef struct packed {
      logic [CountWidth-1:0] touch_count;
      coord_type             touch_x;
      coord_type             touch_y;
   } req_item_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [2:0] swipe_direction;
   } rsp_item_type;

   // True when travel from a to b (a > b) reaches the threshold.
   function automatic logic travel_hit(coord_type a, coord_type b, coord_type thr);
      coord_type diff;
      diff = a - b;
      return (a > b) && (diff >= thr);
   endfunction

   function automatic logic [2:0] swipe_dir(coord_type fx, coord_type fy,
                                            coord_type lx, coord_type ly,
                                            coord_type thr);
      logic [2:0] dir;
      dir = DIR_POINT;
      if (lx != '0 || ly != '0) begin
         if (travel_hit(fx, lx, thr)) dir = DIR_RIGHT;
         if (travel_hit(lx, fx, thr)) dir = DIR_LEFT;
         // Y overrides X
         if (travel_hit(fy, ly, thr)) dir = DIR_UP;
         if (travel_hit(ly, fy, thr)) dir = DIR_DOWN;
      end
      return dir;
   endfunction

endpackage

// ----- hdl/tsd_in_stage.sv -----
`timescale 1ns / 1ps

module tsd_in_stage import tsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = (valid_ff && !advance) || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- hdl/tsd_tracker.sv -----
`timescale 1ns / 1ps

module tsd_tracker import tsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  coord_type    threshold,
   output rsp_item_type result
);

   logic      touching_ff, touching_in;
   coord_type first_x_ff, first_x_in;
   coord_type first_y_ff, first_y_in;
   coord_type last_x_ff, last_x_in;
   coord_type last_y_ff, last_y_in;
   logic      pressed;

   assign pressed = (item.touch_count != '0) && (item.touch_count <= MAX_TOUCHES) &&
                    !(item.touch_x == '0 && item.touch_y == '0);

   always_comb begin
      touching_in            = touching_ff;
      first_x_in             = first_x_ff;
      first_y_in             = first_y_ff;
      last_x_in              = last_x_ff;
      last_y_in              = last_y_ff;
      result.event_kind      = EV_NONE;
      result.swipe_direction = DIR_POINT;
      if (pressed) begin
         if (!touching_ff) begin
            first_x_in        = item.touch_x;
            first_y_in        = item.touch_y;
            last_x_in         = '0;
            last_y_in         = '0;
            touching_in       = 1'b1;
            result.event_kind = EV_START;
         end else begin
            last_x_in = item.touch_x;
            last_y_in = item.touch_y;
         end
      end else if (touching_ff) begin
         touching_in            = 1'b0;
         result.event_kind      = EV_END;
         result.swipe_direction = swipe_dir(first_x_ff, first_y_ff,
                                            last_x_ff, last_y_ff, threshold);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touching_ff <= 1'b0;
         first_x_ff  <= '0;
         first_y_ff  <= '0;
         last_x_ff   <= '0;
         last_y_ff   <= '0;
      end else if (step) begin
         touching_ff <= touching_in;
         first_x_ff  <= first_x_in;
         first_y_ff  <= first_y_in;
         last_x_ff   <= last_x_in;
         last_y_ff   <= last_y_in;
      end
   end

endmodule

// ----- hdl/touch_swipe_detector.sv -----
// Each sample is registered in the input stage, then in the result stage (rsp_valid).
// Throughput: one sample per cycle unless rsp_stall holds the result; the input
// and result registers are the only stages, both held only while rsp_stall is high.
// Reset: synchronous, active high; clears both stages, the gesture state
// and loads the swipe threshold with 30.
`timescale 1ns / 1ps

module touch_swipe_detector import tsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_wr_en,
   input  coord_type    csr_wr_data
);

   coord_type    threshold_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   logic         advance;
   logic         item_valid;
   req_item_type item;
   rsp_item_type result;
   logic         step;

   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign step         = item_valid && advance;
   assign rsp_valid_in = advance ? item_valid : rsp_valid_ff;

   tsd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tsd_tracker u_track (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .threshold (threshold_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- hdl/tsd_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsd_checker import tsd_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item,
   input logic         csr_wr_en,
   input coord_type    csr_wr_data
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item), "stalled result item changed")
   `ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled while output free")
   `ASSERT_IMPLIES(a_dir_only_end, clock, reset, rsp_valid && rsp_item.event_kind != EV_END, rsp_item.swipe_direction == DIR_POINT, "direction without end event")
   `ASSERT_IMPLIES(a_codes_legal, clock, reset, rsp_valid, (rsp_item.event_kind == EV_NONE || rsp_item.event_kind == EV_START || rsp_item.event_kind == EV_END) && rsp_item.swipe_direction <= DIR_DOWN, "illegal result code")

endmodule

bind touch_swipe_detector tsd_checker u_tsd_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import tsd_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int RandomSamples = 1900;
   localparam int PhaseCount = 5;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_wr_en = 1'b0;
   coord_type    csr_wr_data = '0;

   touch_swipe_detector u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // samples waiting to be sent, and events expected back in order
   req_item_type samples_to_send[$];
   rsp_item_type events_due[$];

   // gesture tracker state
   coord_type thr_now = THRESHOLD_RESET;
   logic      pressed_now = 1'b0;
   coord_type orig_x = '0, orig_y = '0, cur_x = '0, cur_y = '0;

   int errors = 0;
   int cycle_count = 0;
   int samples_sent = 0;
   int starts_seen = 0;
   int releases_seen = 0;
   int dir_tally[5] = '{default: 0};

   function automatic logic [2:0] gesture_direction();
      logic [2:0] dir;
      dir = DIR_POINT;
      if (cur_x == '0 && cur_y == '0) return DIR_POINT;
      if (orig_x > cur_x && (orig_x - cur_x) >= thr_now) dir = DIR_RIGHT;
      if (cur_x > orig_x && (cur_x - orig_x) >= thr_now) dir = DIR_LEFT;
      // vertical travel wins over horizontal
      if (orig_y > cur_y && (orig_y - cur_y) >= thr_now) dir = DIR_UP;
      if (cur_y > orig_y && (cur_y - orig_y) >= thr_now) dir = DIR_DOWN;
      return dir;
   endfunction

   function automatic rsp_item_type track_sample(req_item_type s);
      rsp_item_type ev;
      logic         is_touch;
      ev.event_kind = EV_NONE;
      ev.swipe_direction = DIR_POINT;
      is_touch = s.touch_count != '0 && s.touch_count <= MAX_TOUCHES &&
                 !(s.touch_x == '0 && s.touch_y == '0);
      if (is_touch) begin
         if (!pressed_now) begin
            orig_x = s.touch_x;
            orig_y = s.touch_y;
            cur_x = '0;
            cur_y = '0;
            pressed_now = 1'b1;
            ev.event_kind = EV_START;
            starts_seen++;
         end else begin
            cur_x = s.touch_x;
            cur_y = s.touch_y;
         end
      end else if (pressed_now) begin
         ev.swipe_direction = gesture_direction();
         ev.event_kind = EV_END;
         pressed_now = 1'b0;
         releases_seen++;
         dir_tally[ev.swipe_direction]++;
      end
      return ev;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin : drive_proc
      logic         accepted;
      logic         next_valid;
      req_item_type next_item;
      accepted = req_valid && !req_stall;
      next_valid = req_valid;
      next_item = req_item;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (accepted) begin
            events_due.push_back(track_sample(req_item));
            samples_sent++;
            next_valid = 1'b0;
         end
         if (!req_valid || accepted) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (samples_to_send.size() > 0) begin
               next_item = samples_to_send.pop_front();
               next_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_valid <= next_valid;
      req_item <= next_item;
   end

   // Receiver: stall pattern that switches mode every so often.
   int stall_mode = 0;
   int mode_left = 50;

   always @(posedge clock) begin : check_proc
      rsp_item_type want;
      logic         stall_next;
      cycle_count++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (events_due.size() == 0) begin
            $error("event with no sample outstanding: kind %0d dir %0d",
                   rsp_item.event_kind, rsp_item.swipe_direction);
            errors++;
         end else begin
            want = events_due.pop_front();
            if (rsp_item.event_kind !== want.event_kind) begin
               $error("event_kind: expected %0d, got %0d",
                      want.event_kind, rsp_item.event_kind);
               errors++;
            end
            if (rsp_item.swipe_direction !== want.swipe_direction) begin
               $error("swipe_direction: expected %0d, got %0d",
                      want.swipe_direction, rsp_item.swipe_direction);
               errors++;
            end
         end
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: stall_next = 1'b0;
         1: stall_next = ($urandom_range(0, 3) == 0);
         2: stall_next = ($urandom_range(0, 3) != 0);
         default: stall_next = !rsp_stall;
      endcase
      rsp_stall <= stall_next;
   end

   initial begin : watchdog
      wait (cycle_count >= CycleLimit);
      $display("timeout after %0d cycles, %0d events outstanding",
               cycle_count, events_due.size());
      $display("status: fail");
      $finish;
   end

   task automatic queue_sample(logic [7:0] cnt, coord_type x, coord_type y);
      req_item_type s;
      s.touch_count = cnt;
      s.touch_x = x;
      s.touch_y = y;
      samples_to_send.push_back(s);
   endtask

   // hold until nothing is in flight, then let the pipeline settle
   task automatic wait_idle();
      while (samples_to_send.size() != 0 || req_valid || events_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(coord_type value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      thr_now = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic coord_type pick_coord();
      if ($urandom_range(0, 4) == 0)
         return $urandom_range(0, 1) ? coord_type'(4095) : coord_type'(0);
      return coord_type'($urandom);
   endfunction

   // land near the start point or around the swipe boundary most of the time
   function automatic coord_type near_coord(coord_type base, coord_type thr);
      int b, t, v;
      b = int'(base);
      t = int'(thr);
      case ($urandom_range(0, 4))
         0: v = b;
         1: v = b + t + int'($urandom_range(0, 2)) - 1;
         2: v = b - t - int'($urandom_range(0, 2)) + 1;
         3: v = b + int'($urandom_range(0, 8)) - 4;
         default: v = int'($urandom_range(0, 4095));
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return coord_type'(v);
   endfunction

   task automatic queue_gesture(coord_type thr, ref int n);
      coord_type fx, fy, mx, my;
      int        moves;
      fx = pick_coord();
      fy = pick_coord();
      if (fx == '0 && fy == '0) fx = 12'd4095;
      queue_sample(8'($urandom_range(1, 2)), fx, fy);
      moves = $urandom_range(0, 5);
      for (int i = 0; i < moves; i++) begin
         mx = near_coord(fx, thr);
         my = near_coord(fy, thr);
         if (mx == '0 && my == '0) my = 12'd1;
         queue_sample(8'($urandom_range(1, 2)), mx, my);
      end
      case ($urandom_range(0, 2))
         0: queue_sample(8'd0, coord_type'($urandom), coord_type'($urandom));
         1: queue_sample(8'($urandom_range(3, 255)), coord_type'($urandom),
                         coord_type'($urandom));
         default: queue_sample(8'($urandom_range(1, 2)), '0, '0);
      endcase
      n += moves + 2;
   endtask

   initial begin : stimulus
      coord_type thr_list[PhaseCount];
      int        n;
      thr_list[0] = 12'd0;
      thr_list[1] = 12'd4095;
      thr_list[2] = 12'd1;
      thr_list[3] = coord_type'($urandom_range(2, 64));
      thr_list[4] = coord_type'($urandom_range(0, 4095));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: rejected samples, single tap, left, up and down swipes, boundary travel
      queue_sample(8'd0, 12'd4095, 12'd4095);
      queue_sample(8'd3, 12'd100, 12'd100);
      queue_sample(8'd255, 12'd4095, 12'd4095);
      queue_sample(8'd1, 12'd0, 12'd0);
      queue_sample(8'd1, 12'd100, 12'd100);
      queue_sample(8'd0, 12'd100, 12'd100);
      queue_sample(8'd2, 12'd100, 12'd100);
      queue_sample(8'd1, 12'd200, 12'd100);
      queue_sample(8'd3, 12'd5, 12'd5);
      queue_sample(8'd1, 12'd200, 12'd200);
      queue_sample(8'd2, 12'd100, 12'd100);
      queue_sample(8'd2, 12'd0, 12'd0);
      queue_sample(8'd1, 12'd100, 12'd100);
      queue_sample(8'd1, 12'd100, 12'd200);
      queue_sample(8'd1, 12'd4095, 12'd4095);
      queue_sample(8'd0, 12'd0, 12'd0);
      queue_sample(8'd1, 12'd100, 12'd100);
      queue_sample(8'd1, 12'd130, 12'd70);
      queue_sample(8'd128, 12'd2048, 12'd2048);
      queue_sample(8'd1, 12'd100, 12'd100);
      queue_sample(8'd1, 12'd129, 12'd71);
      queue_sample(8'd0, 12'd4095, 12'd0);
      queue_sample(8'd2, 12'd4095, 12'd0);
      queue_sample(8'd1, 12'd0, 12'd4095);
      queue_sample(8'd0, 12'd0, 12'd4095);
      wait_idle();

      for (int p = 0; p < PhaseCount; p++) begin
         write_threshold(thr_list[p]);
         n = 0;
         while (n < RandomSamples / PhaseCount) begin
            if ($urandom_range(0, 9) == 0) begin
               if ($urandom_range(0, 1))
                  queue_sample(8'($urandom), coord_type'($urandom), coord_type'($urandom));
               else
                  queue_sample(8'($urandom_range(0, 3)), pick_coord(), pick_coord());
               n++;
            end else begin
               queue_gesture(thr_list[p], n);
            end
         end
         wait_idle();
      end

      repeat (6) @(posedge clock);
      if (events_due.size() != 0) begin
         $error("%0d events never arrived", events_due.size());
         errors++;
      end
      $display("covered %0d samples: %0d touch starts, %0d releases over thresholds 30, 0, 4095, 1 and random",
               samples_sent, starts_seen, releases_seen);
      $display("release directions point/right/left/up/down: %0d/%0d/%0d/%0d/%0d",
               dir_tally[0], dir_tally[1], dir_tally[2], dir_tally[3], dir_tally[4]);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
